/* sv/u2u_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

  localparam int MaxStringUnits = 4096;
  localparam int QueueDepth     = 4;
  localparam int CountW         = 13;

  localparam logic [1:0] StatusUnit = 2'd0;
  localparam logic [1:0] StatusEnd  = 2'd1;
  localparam logic [1:0] StatusErr  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [15:0]       code_unit;
    logic [1:0]        status;
    logic [CountW-1:0] unit_count;
    logic              last;
  } out_t;

  // one decoded byte's worth of results: one, or a surrogate pair
  typedef struct packed {
    logic pair;
    out_t r0;
    out_t r1;
  } job_t;

endpackage

/* sv/utf8_to_utf16_decoder_unit.sv */
// Top level of the UTF-8 to UTF-16 stream decoder.
// Input channel: one UTF-8 byte per request, end_of_string set on the
// string's final byte. Output channel: UTF-16 code units, each with a status
// (unit mid-string, unit ending string, error ending string), the saturating
// unit count of the string and a last flag on the final result of a byte.
// A byte that completes a scalar is pushed into the queue at its accepting
// edge and then loaded into the output register, which raises out_valid_o;
// a 4-byte scalar gives a surrogate pair as two successive results, high
// unit first.
// Throughput: one byte per cycle in while the queue has room, one result per
// cycle out while out_ready_i is high. The front end decodes combinationally
// and pushes finished jobs into a four-entry queue; the output register
// drains it one result per cycle and holds a surrogate pair for both units.
// Reset clears the decoder state, the queue and the output valid flag.
// When the receiver stalls, results wait in the output register and the
// queue; in_ready_o drops only once the queue is full.
module utf8_to_utf16_decoder_unit #(
  parameter int MAX_STRING_UNITS = u2u_pkg::MaxStringUnits,
  parameter int QUEUE_DEPTH      = u2u_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  u2u_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output u2u_pkg::out_t out_data_o
);

  logic          push, pop, q_full, q_empty;
  u2u_pkg::job_t job_in, job_out;

  u2u_front #(
    .MAX_STRING_UNITS(MAX_STRING_UNITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  u2u_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/u2u_front.sv */
// Front end: byte classification, scalar assembly and result building.
module u2u_front #(
  parameter int MAX_STRING_UNITS = u2u_pkg::MaxStringUnits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  u2u_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output u2u_pkg::job_t job_o
);

  localparam int CntW = $clog2(MAX_STRING_UNITS + 1);

  logic [20:0]     scal_q, scal_d;
  logic [1:0]      pend_q, pend_d;
  logic [2:0]      seqlen_q, seqlen_d;
  logic            disc_q, disc_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt1, cnt2;

  logic        accept, err, done, eos, pair;
  logic [7:0]  b;
  logic [20:0] s, v, scal_cont;
  logic [1:0]  pend_cont;
  logic [1:0]  end_status;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
    logic [CntW-1:0] r;
    r = (x < CntW'(MAX_STRING_UNITS)) ? x + 1'b1 : x;
    return r;
  endfunction

  function automatic logic [u2u_pkg::CountW-1:0] to_out(input logic [CntW-1:0] x);
    logic [CntW+u2u_pkg::CountW-1:0] e;
    e = {{u2u_pkg::CountW{1'b0}}, x};
    return e[u2u_pkg::CountW-1:0];
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;
  assign eos        = in_data_i.end_of_string;
  assign scal_cont  = {scal_q[14:0], b[5:0]};
  assign pend_cont  = pend_q - 2'd1;

  always_comb begin
    scal_d   = scal_q;
    pend_d   = pend_q;
    seqlen_d = seqlen_q;
    disc_d   = disc_q;
    cnt_d    = cnt_q;
    err      = 1'b0;
    done     = 1'b0;
    s        = '0;
    if (disc_q) begin
      if (eos) begin
        scal_d   = '0;
        pend_d   = '0;
        seqlen_d = '0;
        disc_d   = 1'b0;
        cnt_d    = '0;
      end
    end else begin
      if (pend_q == 2'd0) begin
        if (b < 8'h80) begin
          s    = {13'd0, b};
          done = 1'b1;
        end else if (b < 8'hc0 || b >= 8'hf8) begin
          err = 1'b1;
        end else if (b < 8'he0) begin
          seqlen_d = 3'd2;
          scal_d   = {16'd0, b[4:0]};
          pend_d   = 2'd1;
        end else if (b < 8'hf0) begin
          seqlen_d = 3'd3;
          scal_d   = {17'd0, b[3:0]};
          pend_d   = 2'd2;
        end else begin
          seqlen_d = 3'd4;
          scal_d   = {18'd0, b[2:0]};
          pend_d   = 2'd3;
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        scal_d = scal_cont;
        pend_d = pend_cont;
        if (pend_cont == 2'd0) begin
          s = scal_cont;
          case (seqlen_q)
            3'd2:    err = s < 21'h80;
            3'd3:    err = s < 21'h800 || (s >= 21'hd800 && s < 21'he000);
            default: err = s < 21'h10000 || s > 21'h10ffff;
          endcase
          done = !err;
        end
      end
      if (!err && !done && eos) err = 1'b1;
      if (err) begin
        scal_d   = '0;
        pend_d   = '0;
        seqlen_d = '0;
        disc_d   = !eos;
        if (eos) cnt_d = '0;
      end else if (done) begin
        scal_d   = '0;
        seqlen_d = '0;
        cnt_d    = (s >= 21'h10000) ? cnt2 : cnt1;
        if (eos) begin
          pend_d = '0;
          cnt_d  = '0;
        end
      end
    end
  end

  assign cnt1       = sat_inc(cnt_q);
  assign cnt2       = sat_inc(cnt1);
  assign pair       = s >= 21'h10000;
  assign v          = s - 21'h10000;
  assign end_status = eos ? u2u_pkg::StatusEnd : u2u_pkg::StatusUnit;

  always_comb begin
    job_o.pair          = 1'b0;
    job_o.r0.code_unit  = 16'h0000;
    job_o.r0.status     = u2u_pkg::StatusErr;
    job_o.r0.unit_count = to_out(cnt_q);
    job_o.r0.last       = 1'b1;
    job_o.r1.code_unit  = 16'hdc00 | {6'd0, v[9:0]};
    job_o.r1.status     = end_status;
    job_o.r1.unit_count = to_out(cnt2);
    job_o.r1.last       = 1'b1;
    if (!err) begin
      if (pair) begin
        job_o.pair          = 1'b1;
        job_o.r0.code_unit  = 16'hd800 | {6'd0, v[19:10]};
        job_o.r0.status     = u2u_pkg::StatusUnit;
        job_o.r0.unit_count = to_out(cnt1);
        job_o.r0.last       = 1'b0;
      end else begin
        job_o.r0.code_unit  = s[15:0];
        job_o.r0.status     = end_status;
        job_o.r0.unit_count = to_out(cnt1);
      end
    end
  end

  assign push_o = accept && !disc_q && (err || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scal_q   <= '0;
      pend_q   <= '0;
      seqlen_q <= '0;
      disc_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (accept) begin
      scal_q   <= scal_d;
      pend_q   <= pend_d;
      seqlen_q <= seqlen_d;
      disc_q   <= disc_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* sv/u2u_fifo.sv */
// Short job queue between the front end and the output stage.
module u2u_fifo #(
  parameter int Depth = u2u_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u2u_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output u2u_pkg::job_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  u2u_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* sv/u2u_back.sv */
// Output stage: splits surrogate pairs and holds the result register.
module u2u_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  u2u_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output u2u_pkg::out_t out_data_o
);

  logic          valid_q, half_q, load;
  u2u_pkg::out_t data_q;

  assign load        = (!valid_q || out_ready_i) && !q_empty_i;
  // first half of a pair leaves the job at the head of the queue
  assign pop_o       = load && (!job_i.pair || half_q);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    if (load) data_q <= half_q ? job_i.r1 : job_i.r0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        half_q  <= job_i.pair && !half_q;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

/* sv/u2u_checker.sv */
// Port-level checks for the decoder, bound to the top level.
module u2u_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input u2u_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined status code");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == u2u_pkg::StatusErr
      |-> out_data_o.last && out_data_o.code_unit == 16'h0000)
    else $error("malformed error result");

  a_high_surrogate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last
      |-> out_data_o.status == u2u_pkg::StatusUnit
          && out_data_o.code_unit[15:10] == 6'b110110)
    else $error("non-last result is not a high surrogate");

endmodule

bind utf8_to_utf16_decoder_unit u2u_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
